[design/lcp_pps_pkg.sv]
// ----------------------------------------------------------------------------
// lcp_pps_pkg
// Shared types, constants and fixed-point helpers of the pivot solver.
// ----------------------------------------------------------------------------
package lcp_pps_pkg;

  localparam int MaxPairs  = 8;
  localparam int RowLen    = 2 * MaxPairs + 1;
  localparam int TabDepth  = MaxPairs * RowLen;
  localparam int TabAddrW  = $clog2(TabDepth);

  localparam logic [4:0]  RHS_COL = 5'd16;
  localparam logic [3:0]  N_MAX   = 4'd8;
  localparam logic [31:0] FX_ONE  = 32'h0001_0000;
  localparam logic [31:0] FX_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] FX_MIN  = 32'h8000_0000;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_IDENT,
    DP_READ,
    DP_PIVOT,
    DP_SC_MUL,
    DP_SC_WR,
    DP_EL_F,
    DP_EL_MUL,
    DP_EL_WR,
    DP_OUT
  } dp_op_t;

  // Row and column select the tableau entry; flag qualifies the operation.
  typedef struct packed {
    dp_op_t     op;
    logic [2:0] row;
    logic [4:0] col;
    logic       flag;
  } dp_cmd_t;

  typedef struct packed {
    logic rhs_neg;
    logic is_one;
    logic is_zero;
    logic div_busy;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_DIAG_RD,
    ST_DIAG_CHK,
    ST_DIAGZ_RD,
    ST_DIAGZ_CHK,
    ST_DIV,
    ST_SC_RD,
    ST_SC_MUL,
    ST_SC_WR,
    ST_EL_FRD,
    ST_EL_FCHK,
    ST_EL_RD,
    ST_EL_MUL,
    ST_EL_WR,
    ST_FE_RD,
    ST_FE_CHK,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } ctrl_state_t;

  function automatic logic [TabAddrW-1:0] tab_addr(input logic [2:0] row,
                                                   input logic [4:0] col);
    tab_addr = TabAddrW'({row, 4'b0000}) + TabAddrW'(row) + TabAddrW'(col);
  endfunction

  // Magnitude of a signed value; the most negative value maps to 2^31.
  function automatic logic [31:0] fx_mag(input logic [31:0] v);
    fx_mag = v[31] ? (32'd0 - v) : v;
  endfunction

  // Signed value from sign and magnitude, clamped to the 32-bit range.
  function automatic logic [31:0] fx_from_mag(input logic neg, input logic [47:0] mag);
    logic [47:0] lim;
    logic [31:0] m;
    lim = neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
    m = (mag > lim) ? lim[31:0] : mag[31:0];
    fx_from_mag = neg ? (32'd0 - m) : m;
  endfunction

  function automatic logic [31:0] fx_sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      fx_sat_sub = d[32] ? FX_MIN : FX_MAX;
    end else begin
      fx_sat_sub = d[31:0];
    end
  endfunction

endpackage

[design/lcp_pps_ram.sv]
// ----------------------------------------------------------------------------
// lcp_pps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcp_pps_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 136,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/lcp_pps_dpath.sv]
// ----------------------------------------------------------------------------
// lcp_pps_dpath
// Tableau memory, pivot row cache, reciprocal divider and multiplier.
// ----------------------------------------------------------------------------
module lcp_pps_dpath (
  input  logic                    clk,
  input  logic                    rst,
  input  lcp_pps_pkg::dp_cmd_t    cmd,
  output lcp_pps_pkg::dp_status_t status,
  input  logic [2:0]              row_index,
  input  logic [2:0]              col_index,
  input  logic [31:0]             entry_value,
  input  logic                    is_rhs,
  output logic [3:0]              var_index,
  output logic [31:0]             solution_value
);
  import lcp_pps_pkg::*;

  logic                we;
  logic [TabAddrW-1:0] waddr;
  logic [TabAddrW-1:0] raddr;
  logic [31:0]         wdata;
  logic [31:0]         rdata;

  logic [31:0] prow [RowLen];
  logic [31:0] recip;
  logic [31:0] f_reg;
  logic [31:0] a_reg;
  logic [63:0] prod;
  logic        prod_neg;
  logic [31:0] scaled;

  logic [31:0] den;
  logic [31:0] rem;
  logic [32:0] quo;
  logic [5:0]  cnt;
  logic        d_neg;
  logic        busy;
  logic [32:0] trial;

  lcp_pps_ram #(.WIDTH(32), .DEPTH(TabDepth)) u_tab (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign scaled = fx_from_mag(prod_neg, prod[63:16]);
  assign raddr  = tab_addr(cmd.row, cmd.col);
  assign trial  = {rem, quo[32]};

  always_comb begin
    we    = 1'b0;
    waddr = tab_addr(cmd.row, cmd.col);
    wdata = '0;
    case (cmd.op)
      DP_LOAD: begin
        we    = 1'b1;
        waddr = tab_addr(row_index, is_rhs ? RHS_COL : {2'b01, col_index});
        wdata = is_rhs ? entry_value : fx_sat_sub(32'd0, entry_value);
      end
      DP_IDENT: begin
        we    = 1'b1;
        wdata = cmd.flag ? FX_ONE : 32'd0;
      end
      DP_SC_WR: begin
        we    = 1'b1;
        wdata = cmd.flag ? FX_ONE : scaled;
      end
      DP_EL_WR: begin
        we    = 1'b1;
        wdata = fx_sat_sub(a_reg, scaled);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign status.rhs_neg  = rdata[31];
  assign status.is_one   = (rdata == FX_ONE);
  assign status.is_zero  = (rdata == 32'd0);
  assign status.div_busy = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.op == DP_PIVOT) begin
      busy <= 1'b1;
    end else if (busy && cnt == 6'd0) begin
      busy <= 1'b0;
    end
  end

  // Restoring division of 2^32 by the pivot magnitude, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.op == DP_PIVOT) begin
      den   <= fx_mag(rdata);
      d_neg <= rdata[31];
      rem   <= 32'd0;
      quo   <= 33'h1_0000_0000;
      cnt   <= 6'd33;
    end else if (busy) begin
      if (cnt != 6'd0) begin
        if (trial >= {1'b0, den}) begin
          rem <= 32'(trial - {1'b0, den});
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
      end else begin
        recip <= fx_from_mag(d_neg, {15'd0, quo});
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_SC_MUL: begin
        prod     <= 64'(fx_mag(rdata)) * 64'(fx_mag(recip));
        prod_neg <= rdata[31] ^ recip[31];
      end
      DP_SC_WR: begin
        prow[cmd.col] <= wdata;
      end
      DP_EL_F: begin
        f_reg <= rdata;
      end
      DP_EL_MUL: begin
        prod     <= 64'(fx_mag(f_reg)) * 64'(fx_mag(prow[cmd.col]));
        prod_neg <= f_reg[31] ^ prow[cmd.col][31];
        a_reg    <= rdata;
      end
      DP_OUT: begin
        solution_value <= cmd.flag ? rdata : 32'd0;
        var_index      <= cmd.col[3:0];
      end
      default: begin
      end
    endcase
  end

endmodule

[design/lcp_pps_ctrl.sv]
// ----------------------------------------------------------------------------
// lcp_pps_ctrl
// Sequencer for loading, pivot iterations and result output.
// ----------------------------------------------------------------------------
module lcp_pps_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [3:0]              cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_start,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_last,
  output logic                    out_feasible,
  output lcp_pps_pkg::dp_cmd_t    cmd,
  input  lcp_pps_pkg::dp_status_t status
);
  import lcp_pps_pkg::*;

  ctrl_state_t state, state_next;
  logic [3:0]  psize;
  logic [3:0]  n, n_next;
  logic [2:0]  i, i_next;
  logic [4:0]  j, j_next;
  logic [2:0]  row, row_next;
  logic [4:0]  col, col_next;
  logic [4:0]  k, k_next;
  logic [4:0]  iter, iter_next;
  logic [2:0]  prev, prev_next;
  logic        prev_valid, prev_valid_next;
  logic [15:0] basis, basis_next;
  logic        feasible, feasible_next;
  logic        last, last_next;

  logic [3:0]  act_n;
  logic [2:0]  nm1;
  logic [2:0]  orow;
  logic        k_is_z;

  assign cfg_ready    = 1'b1;
  assign in_ready     = (state == ST_IDLE);
  assign out_valid    = (state == ST_OUT_WAIT);
  assign out_last     = last;
  assign out_feasible = feasible;

  assign act_n  = (psize == 4'd0) ? 4'd1 : ((psize > N_MAX) ? N_MAX : psize);
  assign nm1    = 3'(n - 4'd1);
  assign k_is_z = (k < {1'b0, n});
  assign orow   = k_is_z ? k[2:0] : 3'(k - {1'b0, n});

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      psize      <= N_MAX;
      n          <= N_MAX;
      i          <= '0;
      j          <= '0;
      row        <= '0;
      col        <= '0;
      k          <= '0;
      iter       <= '0;
      prev       <= '0;
      prev_valid <= 1'b0;
      basis      <= 16'h00FF;
      feasible   <= 1'b1;
      last       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        psize <= cfg_data;
      end
      state      <= state_next;
      n          <= n_next;
      i          <= i_next;
      j          <= j_next;
      row        <= row_next;
      col        <= col_next;
      k          <= k_next;
      iter       <= iter_next;
      prev       <= prev_next;
      prev_valid <= prev_valid_next;
      basis      <= basis_next;
      feasible   <= feasible_next;
      last       <= last_next;
    end
  end

  always_comb begin
    state_next      = state;
    n_next          = n;
    i_next          = i;
    j_next          = j;
    row_next        = row;
    col_next        = col;
    k_next          = k;
    iter_next       = iter;
    prev_next       = prev;
    prev_valid_next = prev_valid;
    basis_next      = basis;
    feasible_next   = feasible;
    last_next       = last;
    cmd.op          = DP_NOP;
    cmd.row         = i;
    cmd.col         = j;
    cmd.flag        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LOAD;
          if (in_start) begin
            n_next          = act_n;
            i_next          = '0;
            j_next          = '0;
            basis_next      = 16'h00FF;
            prev_valid_next = 1'b0;
            iter_next       = '0;
            state_next      = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.op   = DP_IDENT;
        cmd.flag = ({2'b00, i} == j);
        if (j == {2'b00, nm1}) begin
          j_next = '0;
          if (i == nm1) begin
            state_next = ST_FIND_RD;
          end else begin
            i_next = i + 3'd1;
          end
        end else begin
          j_next = j + 5'd1;
        end
      end
      ST_FIND_RD: begin
        cmd.op     = DP_READ;
        cmd.col    = RHS_COL;
        state_next = ST_FIND_CHK;
      end
      ST_FIND_CHK: begin
        if (status.rhs_neg) begin
          if ((prev_valid && prev == i) || iter > {n, 1'b0}) begin
            i_next        = '0;
            feasible_next = 1'b1;
            state_next    = ST_FE_RD;
          end else begin
            iter_next       = iter + 5'd1;
            prev_next       = i;
            prev_valid_next = 1'b1;
            row_next        = i;
            state_next      = ST_DIAG_RD;
          end
        end else if (i == 3'd0) begin
          feasible_next = 1'b1;
          state_next    = ST_FE_RD;
        end else begin
          i_next     = i - 3'd1;
          state_next = ST_FIND_RD;
        end
      end
      ST_DIAG_RD: begin
        cmd.op     = DP_READ;
        cmd.row    = row;
        cmd.col    = {2'b00, row};
        state_next = ST_DIAG_CHK;
      end
      ST_DIAG_CHK: begin
        if (!status.is_one) begin
          cmd.op                  = DP_PIVOT;
          basis_next[row]         = 1'b1;
          basis_next[{1'b1, row}] = 1'b0;
          col_next                = {2'b00, row};
          i_next                  = '0;
          state_next              = status.is_zero ? ST_FE_RD : ST_DIV;
          feasible_next           = 1'b1;
        end else begin
          state_next = ST_DIAGZ_RD;
        end
      end
      ST_DIAGZ_RD: begin
        cmd.op     = DP_READ;
        cmd.row    = row;
        cmd.col    = {2'b01, row};
        state_next = ST_DIAGZ_CHK;
      end
      ST_DIAGZ_CHK: begin
        if (!status.is_one) begin
          cmd.op                  = DP_PIVOT;
          basis_next[row]         = 1'b0;
          basis_next[{1'b1, row}] = 1'b1;
          col_next                = {2'b01, row};
          i_next                  = '0;
          state_next              = status.is_zero ? ST_FE_RD : ST_DIV;
          feasible_next           = 1'b1;
        end else begin
          i_next     = nm1;
          state_next = ST_FIND_RD;
        end
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          j_next     = '0;
          state_next = ST_SC_RD;
        end
      end
      ST_SC_RD: begin
        cmd.op     = DP_READ;
        cmd.row    = row;
        state_next = ST_SC_MUL;
      end
      ST_SC_MUL: begin
        cmd.op     = DP_SC_MUL;
        state_next = ST_SC_WR;
      end
      ST_SC_WR: begin
        cmd.op   = DP_SC_WR;
        cmd.row  = row;
        cmd.flag = (j == col);
        if (j == RHS_COL) begin
          i_next     = '0;
          state_next = ST_EL_FRD;
        end else begin
          j_next     = j + 5'd1;
          state_next = ST_SC_RD;
        end
      end
      ST_EL_FRD: begin
        if (i == row) begin
          if (i == nm1) begin
            state_next = ST_FIND_RD;
          end else begin
            i_next = i + 3'd1;
          end
        end else begin
          cmd.op     = DP_READ;
          cmd.col    = col;
          state_next = ST_EL_FCHK;
        end
      end
      ST_EL_FCHK: begin
        cmd.op = DP_EL_F;
        if (status.is_zero) begin
          if (i == nm1) begin
            state_next = ST_FIND_RD;
          end else begin
            i_next     = i + 3'd1;
            state_next = ST_EL_FRD;
          end
        end else begin
          j_next     = '0;
          state_next = ST_EL_RD;
        end
      end
      ST_EL_RD: begin
        cmd.op     = DP_READ;
        state_next = ST_EL_MUL;
      end
      ST_EL_MUL: begin
        cmd.op     = DP_EL_MUL;
        state_next = ST_EL_WR;
      end
      ST_EL_WR: begin
        cmd.op = DP_EL_WR;
        if (j == RHS_COL) begin
          if (i == nm1) begin
            state_next = ST_FIND_RD;
          end else begin
            i_next     = i + 3'd1;
            state_next = ST_EL_FRD;
          end
        end else begin
          j_next     = j + 5'd1;
          state_next = ST_EL_RD;
        end
      end
      ST_FE_RD: begin
        cmd.op     = DP_READ;
        cmd.col    = RHS_COL;
        state_next = ST_FE_CHK;
      end
      ST_FE_CHK: begin
        if ((basis[i] || basis[{1'b1, i}]) && status.rhs_neg) begin
          feasible_next = 1'b0;
        end
        if (i == nm1) begin
          k_next     = '0;
          state_next = ST_OUT_RD;
        end else begin
          i_next     = i + 3'd1;
          state_next = ST_FE_RD;
        end
      end
      ST_OUT_RD: begin
        cmd.op     = DP_READ;
        cmd.row    = orow;
        cmd.col    = RHS_COL;
        state_next = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        // The column field carries the variable index for the result register.
        cmd.op     = DP_OUT;
        cmd.row    = orow;
        cmd.col    = k;
        cmd.flag   = k_is_z ? basis[{1'b1, orow}] : basis[orow];
        last_next  = (k == 5'({n, 1'b0} - 5'd1));
        state_next = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_ready) begin
          if (last) begin
            state_next = ST_IDLE;
          end else begin
            k_next     = k + 5'd1;
            state_next = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/lcp_principal_pivot_solver.sv]
// ----------------------------------------------------------------------------
// lcp_principal_pivot_solver
// Principal-pivoting solver for the complementarity problem w = A*z + q.
// ----------------------------------------------------------------------------
// Load transactions are taken one per cycle while idle and write A or q into
// a tableau held in a single-port-read RAM. The transaction with tlast set
// starts the solve: s_tready stays low until the last result has been taken.
// The solve builds the identity part, scans rows for a negative right-hand
// value, and per pivot runs the serial reciprocal divider, scales the pivot
// row and eliminates each other row that needs elimination, one step after
// another, since every tableau access goes through the one RAM read port.
// Results then come out one at a time, 2n of them, z variables first.
module lcp_principal_pivot_solver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,     // problem_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,      // row_index[2:0], col_index[5:3], entry_value[37:6]
  input  logic        s_tuser,      // is_rhs
  input  logic        s_tlast,      // start_solve
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,      // var_index[3:0], solution_value[35:4]
  output logic        m_tuser,      // feasible
  output logic        m_tlast       // last_result
);
  import lcp_pps_pkg::*;

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [3:0]  var_index;
  logic [31:0] solution_value;

  lcp_pps_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_start    (s_tlast),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_last    (m_tlast),
    .out_feasible(m_tuser),
    .cmd         (cmd),
    .status      (status)
  );

  lcp_pps_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .row_index     (s_tdata[2:0]),
    .col_index     (s_tdata[5:3]),
    .entry_value   (s_tdata[37:6]),
    .is_rhs        (s_tuser),
    .var_index     (var_index),
    .solution_value(solution_value)
  );

  assign m_tdata = {4'd0, solution_value, var_index};

endmodule

[design/lcp_pps_checker.sv]
// ----------------------------------------------------------------------------
// lcp_pps_checker
// Port-level checks of the solver's load, solve and output sequencing.
// ----------------------------------------------------------------------------
module lcp_pps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // Loading and result output never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is shown");

  // The transaction that starts a solve closes the input side.
  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input accepted right after a solve start");

  // Inside a result run the input stays closed.
  a_run_closed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("input reopened before the last result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind lcp_principal_pivot_solver lcp_pps_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tlast (s_tlast),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
